// ===== hdl/rrh_pkg.sv =====
// Package for the rotated rectangle hit test.
// Holds default parameter values and the sine series used to build the quarter-wave ROM.
// No dependencies.
package rrh_pkg;

    localparam int COORD_BITS_DEF      = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 4;
    localparam int TRIG_BITS_DEF       = 16;

    // pi in Q30
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    localparam int TAYLOR_TERMS = 7;
    // (2k)(2k+1) for k = 1..7
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    // Sine of a Q30 angle in [0, pi/2], truncating Taylor steps, rounded half up
    // to Q1.(trig_bits-1) and clamped to one.
    function automatic logic [63:0] taylor_sine(input logic [63:0] theta,
                                                input int trig_bits);
        logic [63:0]        t;
        logic signed [64:0] sum;
        logic [63:0]        one;
        logic [63:0]        r;
        t   = theta;
        sum = $signed({1'b0, theta});
        one = 64'd1 << (trig_bits - 1);
        for (int k = 0; k < TAYLOR_TERMS; k++)
        begin
            t = (t * theta) >> 30;
            t = (t * theta) >> 30;
            t = t / TAYLOR_DIV[k];
            if ((k % 2) == 0)
                sum = sum - $signed({1'b0, t});
            else
                sum = sum + $signed({1'b0, t});
        end
        if (sum < 0)
            sum = '0;
        r = (sum[63:0] + (64'd1 << (30 - trig_bits))) >> (31 - trig_bits);
        if (r > one)
            r = one;
        return r;
    endfunction

endpackage

// ===== hdl/rotated_rect_point_hit_test_top.sv =====
// Rotated rectangle hit test, top level.
// Eight-stage pipeline with an on-chip quarter-wave sine ROM; uses rrh_pkg.
//
// Tests whether a point, rotated counter-clockwise about the centre of an axis-aligned
// rectangle by rot_angle (units of 2^-ANGLE_FRAC_BITS degree), lands inside it
// (left and top edges open, right and bottom edges closed). One transfer is taken per
// clock while in_stall is low; back-pressure on out_stall holds the pipeline only once
// every stage is full, so bubbles are squeezed out. Sine and cosine come from one
// constant ROM of 90*2^ANGLE_FRAC_BITS+1 entries with two registered read ports, built
// at elaboration; zero width or height never hits.
module rotated_rect_point_hit_test_top
    import rrh_pkg::*;
#(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int TRIG_BITS       = TRIG_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [COORD_BITS-1:0]      point_x,
    input  logic signed [COORD_BITS-1:0]      point_y,
    input  logic signed [COORD_BITS-1:0]      rect_x,
    input  logic signed [COORD_BITS-1:0]      rect_y,
    input  logic        [COORD_BITS-2:0]      rect_w,
    input  logic        [COORD_BITS-2:0]      rect_h,
    input  logic        [ANGLE_FRAC_BITS+8:0] rot_angle,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              inside_res
);

    localparam int STAGES    = 8;
    localparam int ANG_W     = ANGLE_FRAC_BITS + 9;
    localparam int QUARTER_N = 90 << ANGLE_FRAC_BITS;
    localparam int ADDR_W    = $clog2(QUARTER_N + 1);
    localparam int D_W       = COORD_BITS + 3;
    localparam int TS_W      = TRIG_BITS + 1;
    localparam int P_W       = D_W + TS_W;
    localparam int S_W       = P_W + 1;

    localparam logic [ANG_W-1:0]     QUARTER     = ANG_W'(QUARTER_N);
    localparam logic [ANG_W-1:0]     HALF        = ANG_W'(2 * QUARTER_N);
    localparam logic [ANG_W-1:0]     THREE_Q     = ANG_W'(3 * QUARTER_N);
    localparam logic [ANG_W-1:0]     TURN        = ANG_W'(4 * QUARTER_N);
    localparam logic [ADDR_W-1:0]    QUARTER_A   = ADDR_W'(QUARTER_N);
    localparam logic [TRIG_BITS-1:0] TRIG_ONE    = {1'b1, {(TRIG_BITS-1){1'b0}}};
    localparam logic [63:0]          TWO_QUARTER = 64'(2 * QUARTER_N);

    typedef logic [TRIG_BITS-1:0] rom_t [0:QUARTER_N];

    typedef struct packed {
        logic signed [D_W-1:0]   dx;
        logic signed [D_W-1:0]   dy;
        logic [COORD_BITS-2:0]   w;
        logic [COORD_BITS-2:0]   h;
    } geom_t;

    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] theta;
        for (int a = 0; a <= QUARTER_N; a++)
        begin
            theta  = (64'(a) * PI_Q30 + 64'(QUARTER_N)) / TWO_QUARTER;
            rom[a] = TRIG_BITS'(taylor_sine(theta, TRIG_BITS));
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // pipeline control
    logic [STAGES:1]   vld_reg;
    logic [STAGES:1]   vld_in;
    logic [STAGES+1:1] adv;

    // payload
    geom_t                        geom_reg [1:STAGES-1];
    geom_t                        geom_next;
    logic [ANG_W-1:0]             ang_reg, ang_next;
    logic [1:0]                   quad_reg, quad_next;
    logic [ADDR_W-1:0]            frac_reg, frac_next;
    logic [ADDR_W-1:0]            sin_addr_reg, sin_addr_next;
    logic [ADDR_W-1:0]            cos_addr_reg, cos_addr_next;
    logic [4:3]                   sin_neg_reg, cos_neg_reg;
    logic [TRIG_BITS-1:0]         sin_mag_reg, cos_mag_reg;
    logic signed [TS_W-1:0]       sin_reg, sin_next;
    logic signed [TS_W-1:0]       cos_reg, cos_next;
    logic signed [P_W-1:0]        dxc_reg, dxc_next;
    logic signed [P_W-1:0]        dys_reg, dys_next;
    logic signed [P_W-1:0]        dyc_reg, dyc_next;
    logic signed [P_W-1:0]        dxs_reg, dxs_next;
    logic signed [S_W-1:0]        rot_u_reg, rot_u_next;
    logic signed [S_W-1:0]        rot_v_reg, rot_v_next;
    logic signed [S_W-1:0]        lim_w, lim_h;
    logic                         hit_reg, hit_next;

    assign vld_in = {vld_reg[STAGES-1:1], in_valid};

    always_comb
    begin
        adv[STAGES+1] = !out_stall;
        for (int k = STAGES; k >= 1; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
    end

    assign in_stall   = !adv[1];
    assign out_valid  = vld_reg[STAGES];
    assign inside_res = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            for (int k = 1; k <= STAGES; k++)
                if (adv[k])
                    vld_reg[k] <= vld_in[k];
        end
    end

    // stage 1: doubled offsets from centre, angle reduced to one turn
    always_comb
    begin
        geom_next.dx = (D_W'(point_x) <<< 1) - (D_W'(rect_x) <<< 1)
                       - $signed(D_W'(rect_w));
        geom_next.dy = (D_W'(point_y) <<< 1) - (D_W'(rect_y) <<< 1)
                       - $signed(D_W'(rect_h));
        geom_next.w  = rect_w;
        geom_next.h  = rect_h;
        ang_next     = (rot_angle >= TURN) ? rot_angle - TURN : rot_angle;
    end

    // stage 2: quadrant and offset within it
    always_comb
    begin
        priority if (ang_reg >= THREE_Q)
        begin
            quad_next = 2'd3;
            frac_next = ADDR_W'(ang_reg - THREE_Q);
        end
        else if (ang_reg >= HALF)
        begin
            quad_next = 2'd2;
            frac_next = ADDR_W'(ang_reg - HALF);
        end
        else if (ang_reg >= QUARTER)
        begin
            quad_next = 2'd1;
            frac_next = ADDR_W'(ang_reg - QUARTER);
        end
        else
        begin
            quad_next = 2'd0;
            frac_next = ADDR_W'(ang_reg);
        end
    end

    // stage 3: ROM addresses and signs; cosine is the sine one quadrant on
    always_comb
    begin
        sin_addr_next = quad_reg[0] ? QUARTER_A - frac_reg : frac_reg;
        cos_addr_next = quad_reg[0] ? frac_reg : QUARTER_A - frac_reg;
    end

    // stage 5: apply signs
    always_comb
    begin
        sin_next = sin_neg_reg[4] ? -$signed({1'b0, sin_mag_reg}) : $signed({1'b0, sin_mag_reg});
        cos_next = cos_neg_reg[4] ? -$signed({1'b0, cos_mag_reg}) : $signed({1'b0, cos_mag_reg});
    end

    // stage 6: products
    always_comb
    begin
        dxc_next = geom_reg[5].dx * cos_reg;
        dys_next = geom_reg[5].dy * sin_reg;
        dyc_next = geom_reg[5].dy * cos_reg;
        dxs_next = geom_reg[5].dx * sin_reg;
    end

    // stage 7: rotated offsets
    always_comb
    begin
        rot_u_next = S_W'(dxc_reg) - S_W'(dys_reg);
        rot_v_next = S_W'(dyc_reg) + S_W'(dxs_reg);
    end

    // stage 8: box test in product scale
    always_comb
    begin
        lim_w    = $signed(S_W'({geom_reg[7].w, {(TRIG_BITS-1){1'b0}}}));
        lim_h    = $signed(S_W'({geom_reg[7].h, {(TRIG_BITS-1){1'b0}}}));
        hit_next = (rot_u_reg > -lim_w) && (rot_u_reg <= lim_w)
                   && (rot_v_reg > -lim_h) && (rot_v_reg <= lim_h);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            geom_reg[1] <= geom_next;
            ang_reg     <= ang_next;
        end
        for (int k = 2; k <= STAGES-1; k++)
            if (adv[k])
                geom_reg[k] <= geom_reg[k-1];
        if (adv[2])
        begin
            quad_reg <= quad_next;
            frac_reg <= frac_next;
        end
        if (adv[3])
        begin
            sin_addr_reg   <= sin_addr_next;
            cos_addr_reg   <= cos_addr_next;
            sin_neg_reg[3] <= quad_reg[1];
            cos_neg_reg[3] <= quad_reg[1] ^ quad_reg[0];
        end
        if (adv[4])
        begin
            sin_mag_reg    <= SINE_ROM[sin_addr_reg];
            cos_mag_reg    <= SINE_ROM[cos_addr_reg];
            sin_neg_reg[4] <= sin_neg_reg[3];
            cos_neg_reg[4] <= cos_neg_reg[3];
        end
        if (adv[5])
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
        if (adv[6])
        begin
            dxc_reg <= dxc_next;
            dys_reg <= dys_next;
            dyc_reg <= dyc_next;
            dxs_reg <= dxs_next;
        end
        if (adv[7])
        begin
            rot_u_reg <= rot_u_next;
            rot_v_reg <= rot_v_next;
        end
        if (adv[8])
            hit_reg <= hit_next;
    end

    // input is held off only when the whole pipe is full and the output is blocked
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while pipeline has room");

    // sine and cosine addresses always sit at complementary points of the quarter wave
    a_addr_complement: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> ((ADDR_W+1)'(sin_addr_reg) + (ADDR_W+1)'(cos_addr_reg)
                        == (ADDR_W+1)'(QUARTER_A)))
        else $error("sine and cosine addresses out of step");

    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] |-> (sin_mag_reg <= TRIG_ONE && cos_mag_reg <= TRIG_ONE))
        else $error("ROM magnitude above one");

    a_zero_size_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[7] && adv[8] && (geom_reg[7].w == '0 || geom_reg[7].h == '0))
        |=> !hit_reg)
        else $error("zero-size rectangle reported a hit");

endmodule
